@@ hdl/smcrn_pkg.sv @@
// Package with types, constants and state codes of the SM co-run resource negotiator.
`timescale 1ns / 1ps
`default_nettype none
package smcrn_pkg;

  localparam int SM_COUNT         = 30;
  localparam int MAX_PROFILES     = 64;
  localparam int SM_REG_CAPACITY  = 65536;
  localparam int SM_SMEM_CAPACITY = 49152;

  localparam int PROF_AW = $clog2(MAX_PROFILES);
  localparam int CNT_W   = $clog2(MAX_PROFILES + 1);
  localparam int SM_W    = (SM_COUNT > 1) ? $clog2(SM_COUNT) : 1;
  localparam int SMC_W   = $clog2(SM_COUNT + 1);

  localparam int OP_W       = 2;
  localparam int SMF_W      = 5;
  localparam int TB_W       = 6;
  localparam int KEY_W      = 32;
  localparam int REGS_W     = 17;
  localparam int SMEM_W     = 16;
  localparam int RANK_W     = 6;
  localparam int IDX_W      = 5;
  localparam int LEFT_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};

  localparam int PRODX_W = TB_W + REGS_W;
  localparam int MULY_W  = REGS_W;
  localparam int PROD_W  = PRODX_W + MULY_W;
  localparam int USE_W   = PRODX_W + SMF_W + 1;
  localparam int CAP_MAX = (SM_REG_CAPACITY > SM_SMEM_CAPACITY) ?
                           SM_REG_CAPACITY : SM_SMEM_CAPACITY;
  localparam int DIV_W   = $clog2(CAP_MAX + 1);
  localparam int DVS_W   = REGS_W;
  localparam int ARITH_W = ((DIV_W > PRODX_W) ? DIV_W : PRODX_W) + 2;
  localparam int Q_W     = (DIV_W > LEFT_W) ? DIV_W : LEFT_W;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REGS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMEM_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMEM_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGS_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMEM_C = 3'd5;

  typedef struct packed {
    logic [SMF_W-1:0] sm;
    logic [TB_W-1:0]  tb;
    logic [KEY_W-1:0] key;
  } profile_t;

  localparam int PROF_W = $bits(profile_t);

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SMF_W-1:0] sm_count;
    logic [TB_W-1:0]  blocks_per_sm;
    logic [KEY_W-1:0] time_key;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [RANK_W-1:0] rank_a;
    logic [RANK_W-1:0] rank_b;
    logic [IDX_W-1:0]  sm_index;
    logic              hosts_a;
    logic              hosts_b;
    logic              hosts_c;
    logic [LEFT_W-1:0] leftover_blocks_c;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SORT_RD_I,
    S_SORT_LAT_I,
    S_SORT_RD_J,
    S_SORT_CMP_J,
    S_SORT_WR,
    S_LOOP,
    S_TRIAL,
    S_TR_LAT,
    S_TR_M0,
    S_TR_M1,
    S_TR_M2,
    S_TR_M3,
    S_TR_M4,
    S_TR_WALK,
    S_TRET,
    S_US_M0,
    S_US_M1,
    S_US_ADD,
    S_T2_SET,
    S_CHOOSE,
    S_DECIDE,
    S_NF_WAIT,
    S_F_CALC,
    S_F_DIVR,
    S_F_WR,
    S_F_DIVS,
    S_F_WS,
    S_F_OUT,
    S_F_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RET_T0,
    RET_T1,
    RET_T2,
    RET_FINAL
  } ret_t;

endpackage
`default_nettype wire

@@ hdl/smcrn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module smcrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/smcrn_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module smcrn_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smcrn_pkg::div_req_t req,
  output smcrn_pkg::div_rsp_t      rsp
);
  import smcrn_pkg::*;

  localparam int REM_W = DVS_W + 1;
  localparam int STP_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [STP_W-1:0] step_r;
  logic [DIV_W-1:0] quo_r;
  logic [REM_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [REM_W-1:0] rem_sh;
  logic             ge;

  assign rem_sh = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STP_W'(DIV_W - 1);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        quo_r <= {quo_r[DIV_W-2:0], ge};
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

@@ hdl/sm_corun_resource_negotiator_core.sv @@
// Top level of the SM co-run resource negotiator: profile stores, sort, trials and report.
//
//  channel | ports                         | direction | beat
//  --------+-------------------------------+-----------+--------------------------------
//  in      | in_valid, in_ready, in_data   | input     | one load or run command
//  out     | out_valid, out_ready, out_data| output    | one SM report, or one not-found
//  cfg     | cfg_we, cfg_index, cfg_wdata  | input     | one register write, no wait
//
// A load beat is stored as it is accepted. A run sorts both lists by ranking over the longer
// list, then each pairing step runs up to three trials on the shared multiplier and fit
// compare, and each SM report costs up to two passes of the one-bit-per-cycle divider,
// plus the wait for out_ready. Reset clears the list counts, the output valid and every
// configuration register but CFG_REGS_C, which reset sets to one.
// in_ready is high only while no command is in progress; a stalled out beat holds the run.
`timescale 1ns / 1ps
`default_nettype none
module sm_corun_resource_negotiator_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire smcrn_pkg::in_item_t                   in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output smcrn_pkg::out_item_t                       out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [smcrn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [smcrn_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import smcrn_pkg::*;

  localparam int CMP_W = ((SMC_W > SMF_W) ? SMC_W : SMF_W) + 1;

  state_t state_r, state_nxt;

  logic [REGS_W-1:0] regs_a_r, regs_b_r, regs_c_r;
  logic [SMEM_W-1:0] smem_a_r, smem_b_r, smem_c_r;

  logic [CNT_W-1:0] count_a_r, count_b_r, max_cnt;
  logic [CNT_W-1:0] i_r, j_r, rank_a_r, rank_b_r;
  profile_t         item_a_r, item_b_r;

  logic [CNT_W-1:0] a_r, b_r, ta_r, tb_r;
  logic             flag_r, s1_r, s2_r, ok_r;
  logic [USE_W-1:0] ru1_r, ru2_r, acc_r, use_sum;
  ret_t             ret_r;

  profile_t           pa_r, pb_r;
  logic [PRODX_W-1:0] ra_r, sa_r, rb_r, sb_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PRODX_W-1:0] mul_x;
  logic [MULY_W-1:0]  mul_y;

  logic [SM_W-1:0]           w_r;
  logic [SMC_W-1:0]          cnt_r, cnt_inc;
  logic                      stop_r, ha_r, hb_r;
  logic signed [ARITH_W-1:0] r_r, s_r;
  logic [Q_W-1:0]            q_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic [PROF_W-1:0] raw_a_q, raw_b_q, srt_a_q, srt_b_q;
  profile_t          raw_a_d, raw_b_d;
  logic              raw_a_we, raw_b_we, srt_a_we, srt_b_we;
  logic [PROF_AW-1:0] raw_raddr, srt_a_raddr, srt_b_raddr;
  profile_t          in_prof;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      in_acc, out_acc;
  logic                      host_a, fit, fit_use, reach;
  logic signed [ARITH_W-1:0] lr_a, lr_b, ls_a, ls_b;
  logic                      less_a, less_b;
  logic [LEFT_W-1:0]         c_val;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid_r && out_ready;
  assign max_cnt = (count_a_r > count_b_r) ? count_a_r : count_b_r;
  assign raw_a_d = profile_t'(raw_a_q);
  assign raw_b_d = profile_t'(raw_b_q);
  assign in_prof = '{sm: in_data.sm_count, tb: in_data.blocks_per_sm, key: in_data.time_key};

  assign less_a = (raw_a_d.key < item_a_r.key) ||
                  ((raw_a_d.key == item_a_r.key) && (j_r < i_r));
  assign less_b = (raw_b_d.key < item_b_r.key) ||
                  ((raw_b_d.key == item_b_r.key) && (j_r < i_r));

  assign host_a  = CMP_W'(w_r) < CMP_W'(pa_r.sm);
  assign lr_a    = ARITH_W'(SM_REG_CAPACITY) - (host_a ? ARITH_W'(ra_r) : '0);
  assign ls_a    = ARITH_W'(SM_SMEM_CAPACITY) - (host_a ? ARITH_W'(sa_r) : '0);
  assign lr_b    = lr_a - ARITH_W'(rb_r);
  assign ls_b    = ls_a - ARITH_W'(sb_r);
  assign fit     = !lr_b[ARITH_W-1] && !ls_b[ARITH_W-1];
  assign fit_use = (state_r == S_F_CALC) ? (fit && !stop_r) : fit;
  assign cnt_inc = cnt_r + SMC_W'(fit_use);
  assign reach   = CMP_W'(cnt_inc) >= CMP_W'(pb_r.sm);
  assign use_sum = acc_r + prod_r[USE_W-1:0];
  assign c_val   = (q_r > Q_W'(LEFT_MAX)) ? LEFT_MAX : q_r[LEFT_W-1:0];

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state_r)
      S_TR_M0: begin
        mul_x = PRODX_W'(pa_r.tb);
        mul_y = MULY_W'(regs_a_r);
      end
      S_TR_M1: begin
        mul_x = PRODX_W'(pa_r.tb);
        mul_y = MULY_W'(smem_a_r);
      end
      S_TR_M2: begin
        mul_x = PRODX_W'(pb_r.tb);
        mul_y = MULY_W'(regs_b_r);
      end
      S_TR_M3: begin
        mul_x = PRODX_W'(pb_r.tb);
        mul_y = MULY_W'(smem_b_r);
      end
      S_US_M0: begin
        mul_x = ra_r;
        mul_y = MULY_W'(pa_r.sm);
      end
      S_US_M1: begin
        mul_x = rb_r;
        mul_y = MULY_W'(pb_r.sm);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.op == OP_RUN)) begin
          state_nxt = (max_cnt == '0) ? S_LOOP : S_SORT_RD_I;
        end
      end
      S_SORT_RD_I:  state_nxt = S_SORT_LAT_I;
      S_SORT_LAT_I: state_nxt = S_SORT_RD_J;
      S_SORT_RD_J:  state_nxt = S_SORT_CMP_J;
      S_SORT_CMP_J: state_nxt = (j_r + CNT_W'(1) == max_cnt) ? S_SORT_WR : S_SORT_RD_J;
      S_SORT_WR:    state_nxt = (i_r + CNT_W'(1) == max_cnt) ? S_LOOP : S_SORT_RD_I;
      S_LOOP: begin
        state_nxt = ((a_r < count_a_r) && (b_r < count_b_r)) ? S_TRIAL : S_DECIDE;
      end
      S_TRIAL: begin
        state_nxt = ((ta_r >= count_a_r) || (tb_r >= count_b_r)) ? S_TRET : S_TR_LAT;
      end
      S_TR_LAT: state_nxt = S_TR_M0;
      S_TR_M0:  state_nxt = S_TR_M1;
      S_TR_M1:  state_nxt = S_TR_M2;
      S_TR_M2:  state_nxt = S_TR_M3;
      S_TR_M3:  state_nxt = S_TR_M4;
      S_TR_M4:  state_nxt = S_TR_WALK;
      S_TR_WALK: begin
        if (reach || (w_r == SM_W'(SM_COUNT - 1))) begin
          state_nxt = S_TRET;
        end
      end
      S_TRET: begin
        unique case (ret_r)
          RET_T0:    state_nxt = ok_r ? S_DECIDE : S_TRIAL;
          RET_T1:    state_nxt = ok_r ? S_US_M0 : S_T2_SET;
          RET_T2:    state_nxt = ok_r ? S_US_M0 : S_CHOOSE;
          RET_FINAL: state_nxt = S_F_CALC;
          default:   state_nxt = S_DECIDE;
        endcase
      end
      S_US_M0:  state_nxt = S_US_M1;
      S_US_M1:  state_nxt = S_US_ADD;
      S_US_ADD: state_nxt = (ret_r == RET_T1) ? S_T2_SET : S_CHOOSE;
      S_T2_SET: state_nxt = S_TRIAL;
      S_CHOOSE: state_nxt = (s1_r || s2_r) ? S_DECIDE : S_LOOP;
      S_DECIDE: begin
        state_nxt = (!flag_r || (a_r >= count_a_r) || (b_r >= count_b_r)) ?
                    S_NF_WAIT : S_TRIAL;
      end
      S_NF_WAIT: state_nxt = out_acc ? S_DONE : S_NF_WAIT;
      S_F_CALC:  state_nxt = S_F_DIVR;
      S_F_DIVR: begin
        priority if (r_r[ARITH_W-1]) begin
          state_nxt = S_F_OUT;
        end else if (regs_c_r == '0) begin
          state_nxt = S_F_DIVS;
        end else begin
          state_nxt = S_F_WR;
        end
      end
      S_F_WR: state_nxt = div_rsp.done ? S_F_DIVS : S_F_WR;
      S_F_DIVS: begin
        priority if (smem_c_r == '0 || s_r[ARITH_W-1]) begin
          state_nxt = S_F_OUT;
        end else begin
          state_nxt = S_F_WS;
        end
      end
      S_F_WS:  state_nxt = div_rsp.done ? S_F_OUT : S_F_WS;
      S_F_OUT: state_nxt = S_F_WAIT;
      S_F_WAIT: begin
        if (out_acc) begin
          state_nxt = (w_r == SM_W'(SM_COUNT - 1)) ? S_DONE : S_F_CALC;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state_r == S_IDLE);
    raw_a_we         = in_acc && (in_data.op == OP_LOAD_A) && (count_a_r < CNT_W'(MAX_PROFILES));
    raw_b_we         = in_acc && (in_data.op == OP_LOAD_B) && (count_b_r < CNT_W'(MAX_PROFILES));
    raw_raddr        = (state_r == S_SORT_RD_I) ? i_r[PROF_AW-1:0] : j_r[PROF_AW-1:0];
    srt_a_we         = (state_r == S_SORT_WR) && (i_r < count_a_r);
    srt_b_we         = (state_r == S_SORT_WR) && (i_r < count_b_r);
    srt_a_raddr      = ta_r[PROF_AW-1:0];
    srt_b_raddr      = tb_r[PROF_AW-1:0];
    div_req.start    = ((state_r == S_F_DIVR) && !r_r[ARITH_W-1] && (regs_c_r != '0)) ||
                       ((state_r == S_F_DIVS) && (smem_c_r != '0) && !s_r[ARITH_W-1]);
    div_req.dividend = (state_r == S_F_DIVR) ? DIV_W'(r_r) : DIV_W'(s_r);
    div_req.divisor  = (state_r == S_F_DIVR) ? DVS_W'(regs_c_r) : DVS_W'(smem_c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_a_r <= '0;
      smem_a_r <= '0;
      regs_b_r <= '0;
      smem_b_r <= '0;
      regs_c_r <= REGS_W'(1);
      smem_c_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGS_A: regs_a_r <= cfg_wdata[REGS_W-1:0];
        CFG_SMEM_A: smem_a_r <= cfg_wdata[SMEM_W-1:0];
        CFG_REGS_B: regs_b_r <= cfg_wdata[REGS_W-1:0];
        CFG_SMEM_B: smem_b_r <= cfg_wdata[SMEM_W-1:0];
        CFG_REGS_C: regs_c_r <= cfg_wdata[REGS_W-1:0];
        CFG_SMEM_C: smem_c_r <= cfg_wdata[SMEM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= mul_x * mul_y;
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (raw_a_we) begin
            count_a_r <= count_a_r + CNT_W'(1);
          end
          if (raw_b_we) begin
            count_b_r <= count_b_r + CNT_W'(1);
          end
          i_r    <= '0;
          a_r    <= '0;
          b_r    <= '0;
          flag_r <= 1'b0;
        end
        S_SORT_LAT_I: begin
          item_a_r <= raw_a_d;
          item_b_r <= raw_b_d;
          j_r      <= '0;
          rank_a_r <= '0;
          rank_b_r <= '0;
        end
        S_SORT_CMP_J: begin
          if ((j_r < count_a_r) && less_a) begin
            rank_a_r <= rank_a_r + CNT_W'(1);
          end
          if ((j_r < count_b_r) && less_b) begin
            rank_b_r <= rank_b_r + CNT_W'(1);
          end
          j_r <= j_r + CNT_W'(1);
        end
        S_SORT_WR: i_r <= i_r + CNT_W'(1);
        S_LOOP: begin
          ta_r  <= a_r;
          tb_r  <= b_r;
          ret_r <= RET_T0;
          s1_r  <= 1'b0;
          s2_r  <= 1'b0;
          ru1_r <= '0;
          ru2_r <= '0;
        end
        S_TRIAL: ok_r <= 1'b0;
        S_TR_LAT: begin
          pa_r <= profile_t'(srt_a_q);
          pb_r <= profile_t'(srt_b_q);
        end
        S_TR_M1: ra_r <= prod_r[PRODX_W-1:0];
        S_TR_M2: sa_r <= prod_r[PRODX_W-1:0];
        S_TR_M3: rb_r <= prod_r[PRODX_W-1:0];
        S_TR_M4: begin
          sb_r  <= prod_r[PRODX_W-1:0];
          w_r   <= '0;
          cnt_r <= '0;
        end
        S_TR_WALK: begin
          cnt_r <= cnt_inc;
          if (reach) begin
            ok_r <= 1'b1;
          end else if (w_r != SM_W'(SM_COUNT - 1)) begin
            w_r <= w_r + SM_W'(1);
          end
        end
        S_TRET: begin
          unique case (ret_r)
            RET_T0: begin
              if (ok_r) begin
                flag_r <= 1'b1;
              end else begin
                tb_r  <= b_r + CNT_W'(1);
                ret_r <= RET_T1;
              end
            end
            RET_T1: s1_r <= ok_r;
            RET_T2: s2_r <= ok_r;
            RET_FINAL: begin
              w_r    <= '0;
              cnt_r  <= '0;
              stop_r <= 1'b0;
            end
            default: ;
          endcase
        end
        S_US_M1: acc_r <= prod_r[USE_W-1:0];
        S_US_ADD: begin
          if (ret_r == RET_T1) begin
            ru1_r <= use_sum;
          end else begin
            ru2_r <= use_sum;
          end
        end
        S_T2_SET: begin
          ta_r  <= a_r + CNT_W'(1);
          tb_r  <= b_r;
          ret_r <= RET_T2;
        end
        S_CHOOSE: begin
          if (s1_r || s2_r) begin
            flag_r <= 1'b1;
            priority if ((ru1_r != '0) && (ru2_r != '0)) begin
              if (ru1_r < ru2_r) begin
                b_r <= b_r + CNT_W'(1);
              end else begin
                a_r <= a_r + CNT_W'(1);
              end
            end else if (ru1_r != '0) begin
              b_r <= b_r + CNT_W'(1);
            end else begin
              a_r <= a_r + CNT_W'(1);
            end
          end else begin
            a_r <= a_r + CNT_W'(1);
            b_r <= b_r + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          if (!flag_r || (a_r >= count_a_r) || (b_r >= count_b_r)) begin
            out_data_r  <= '{last: 1'b1, default: '0};
            out_valid_r <= 1'b1;
          end else begin
            ta_r  <= a_r;
            tb_r  <= b_r;
            ret_r <= RET_FINAL;
          end
        end
        S_F_CALC: begin
          ha_r   <= host_a;
          hb_r   <= fit_use;
          r_r    <= fit_use ? lr_b : lr_a;
          s_r    <= fit_use ? ls_b : ls_a;
          cnt_r  <= cnt_inc;
          stop_r <= stop_r || reach;
        end
        S_F_DIVR: begin
          priority if (r_r[ARITH_W-1]) begin
            q_r <= '0;
          end else if (regs_c_r == '0) begin
            q_r <= Q_W'(LEFT_MAX);
          end else begin
            q_r <= q_r;
          end
        end
        S_F_WR: begin
          if (div_rsp.done) begin
            q_r <= Q_W'(div_rsp.quotient);
          end
        end
        S_F_DIVS: begin
          if ((smem_c_r != '0) && s_r[ARITH_W-1]) begin
            q_r <= '0;
          end
        end
        S_F_WS: begin
          if (div_rsp.done && (Q_W'(div_rsp.quotient) < q_r)) begin
            q_r <= Q_W'(div_rsp.quotient);
          end
        end
        S_F_OUT: begin
          out_data_r.found             <= 1'b1;
          out_data_r.rank_a            <= RANK_W'(a_r);
          out_data_r.rank_b            <= RANK_W'(b_r);
          out_data_r.sm_index          <= IDX_W'(w_r);
          out_data_r.hosts_a           <= ha_r;
          out_data_r.hosts_b           <= hb_r;
          out_data_r.hosts_c           <= (c_val != '0);
          out_data_r.leftover_blocks_c <= c_val;
          out_data_r.last              <= (w_r == SM_W'(SM_COUNT - 1));
          out_valid_r                  <= 1'b1;
        end
        S_F_WAIT: begin
          if (out_acc && (w_r != SM_W'(SM_COUNT - 1))) begin
            w_r <= w_r + SM_W'(1);
          end
        end
        S_DONE: begin
          count_a_r <= '0;
          count_b_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  smcrn_ram #(.WIDTH(PROF_W), .DEPTH(MAX_PROFILES)) u_raw_a (
    .clk   (clk),
    .we    (raw_a_we),
    .waddr (count_a_r[PROF_AW-1:0]),
    .wdata (in_prof),
    .raddr (raw_raddr),
    .rdata (raw_a_q)
  );

  smcrn_ram #(.WIDTH(PROF_W), .DEPTH(MAX_PROFILES)) u_raw_b (
    .clk   (clk),
    .we    (raw_b_we),
    .waddr (count_b_r[PROF_AW-1:0]),
    .wdata (in_prof),
    .raddr (raw_raddr),
    .rdata (raw_b_q)
  );

  smcrn_ram #(.WIDTH(PROF_W), .DEPTH(MAX_PROFILES)) u_srt_a (
    .clk   (clk),
    .we    (srt_a_we),
    .waddr (rank_a_r[PROF_AW-1:0]),
    .wdata (item_a_r),
    .raddr (srt_a_raddr),
    .rdata (srt_a_q)
  );

  smcrn_ram #(.WIDTH(PROF_W), .DEPTH(MAX_PROFILES)) u_srt_b (
    .clk   (clk),
    .we    (srt_b_we),
    .waddr (rank_b_r[PROF_AW-1:0]),
    .wdata (item_b_r),
    .raddr (srt_b_raddr),
    .rdata (srt_b_q)
  );

  smcrn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
`default_nettype wire

@@ tb/sm_corun_resource_negotiator_core_tb.sv @@
// Self-checking testbench for the SM co-run resource negotiator core.
`timescale 1ns / 1ps
`default_nettype none
module sm_corun_resource_negotiator_core_tb;
  import smcrn_pkg::*;

  class negotiator_sb;
    profile_t  list_a[MAX_PROFILES];
    profile_t  list_b[MAX_PROFILES];
    int        cnt_a;
    int        cnt_b;
    longint    regs_left[SM_COUNT];
    longint    smem_left[SM_COUNT];
    bit [1:0]  marks[SM_COUNT];
    longint    rpb_a, spb_a, rpb_b, spb_b, rpb_c, spb_c;
    out_item_t report_q[$];
    int        errors;
    int        runs;
    int        found_runs;
    int        reports;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_REGS_A: rpb_a = val;
        CFG_SMEM_A: spb_a = val[SMEM_W-1:0];
        CFG_REGS_B: rpb_b = val;
        CFG_SMEM_B: spb_b = val[SMEM_W-1:0];
        CFG_REGS_C: rpb_c = val;
        CFG_SMEM_C: spb_c = val[SMEM_W-1:0];
        default: ;
      endcase
    endfunction

    function void sort_list(ref profile_t p[MAX_PROFILES], input int n);
      profile_t t;
      int j;
      for (int i = 1; i < n; i++) begin
        t = p[i];
        j = i;
        while (j > 0 && p[j-1].key > t.key) begin
          p[j] = p[j-1];
          j--;
        end
        p[j] = t;
      end
    endfunction

    function bit try_pair(int ia, int ib);
      int n;
      int placed;
      longint ra, sa, rb, sb;
      if (ia >= cnt_a || ib >= cnt_b) return 0;
      for (int i = 0; i < SM_COUNT; i++) begin
        regs_left[i] = SM_REG_CAPACITY;
        smem_left[i] = SM_SMEM_CAPACITY;
        marks[i] = 2'b00;
      end
      n = (list_a[ia].sm < SM_COUNT) ? list_a[ia].sm : SM_COUNT;
      ra = longint'(list_a[ia].tb) * rpb_a;
      sa = longint'(list_a[ia].tb) * spb_a;
      for (int i = 0; i < n; i++) begin
        regs_left[i] -= ra;
        smem_left[i] -= sa;
        marks[i][0] = 1'b1;
      end
      rb = longint'(list_b[ib].tb) * rpb_b;
      sb = longint'(list_b[ib].tb) * spb_b;
      placed = 0;
      for (int i = 0; i < SM_COUNT; i++) begin
        if (regs_left[i] - rb >= 0 && smem_left[i] - sb >= 0) begin
          regs_left[i] -= rb;
          smem_left[i] -= sb;
          marks[i][1] = 1'b1;
          placed++;
        end
        if (placed >= list_b[ib].sm) return 1;
      end
      return 0;
    endfunction

    function longint reg_usage(int ia, int ib);
      return longint'(list_a[ia].tb) * rpb_a * list_a[ia].sm +
             longint'(list_b[ib].tb) * rpb_b * list_b[ib].sm;
    endfunction

    function longint c_fit(longint r, longint s);
      longint q;
      if (r < 0) return 0;
      q = (rpb_c != 0) ? r / rpb_c : longint'(LEFT_MAX);
      if (spb_c != 0) begin
        if (s < 0) return 0;
        if (s / spb_c < q) q = s / spb_c;
      end
      if (q > longint'(LEFT_MAX)) q = LEFT_MAX;
      return q;
    endfunction

    function void negotiate();
      int a, b;
      bit ok;
      longint u1, u2, c;
      out_item_t r;
      a = 0;
      b = 0;
      ok = 0;
      runs++;
      sort_list(list_a, cnt_a);
      sort_list(list_b, cnt_b);
      while (a < cnt_a && b < cnt_b && !ok) begin
        u1 = 0;
        u2 = 0;
        if (try_pair(a, b)) begin
          ok = 1;
          break;
        end
        if (try_pair(a, b + 1)) begin
          ok = 1;
          u1 = reg_usage(a, b + 1);
        end
        if (try_pair(a + 1, b)) begin
          ok = 1;
          u2 = reg_usage(a + 1, b);
        end
        if (ok) begin
          if (u1 > 0 && u2 > 0) begin
            if (u1 < u2) b++; else a++;
          end else if (u1 > 0) begin
            b++;
          end else begin
            a++;
          end
          break;
        end
        a++;
        b++;
      end
      if (!ok || a >= cnt_a || b >= cnt_b) begin
        r = '0;
        r.last = 1'b1;
        report_q.insert(report_q.size(), r);
      end else begin
        found_runs++;
        void'(try_pair(a, b));
        for (int i = 0; i < SM_COUNT; i++) begin
          c = c_fit(regs_left[i], smem_left[i]);
          r.found = 1'b1;
          r.rank_a = a[RANK_W-1:0];
          r.rank_b = b[RANK_W-1:0];
          r.sm_index = i[IDX_W-1:0];
          r.hosts_a = marks[i][0];
          r.hosts_b = marks[i][1];
          r.hosts_c = (c > 0);
          r.leftover_blocks_c = c[LEFT_W-1:0];
          r.last = (i == SM_COUNT - 1);
          report_q.insert(report_q.size(), r);
        end
      end
      cnt_a = 0;
      cnt_b = 0;
    endfunction

    function void note_input(in_item_t it);
      profile_t p;
      p.sm = it.sm_count;
      p.tb = it.blocks_per_sm;
      p.key = it.time_key;
      case (it.op)
        OP_LOAD_A: if (cnt_a < MAX_PROFILES) list_a[cnt_a++] = p;
        OP_LOAD_B: if (cnt_b < MAX_PROFILES) list_b[cnt_b++] = p;
        OP_RUN: negotiate();
        default: ;
      endcase
    endfunction

    function void cmp(string name, longint e, longint g);
      if (e != g) begin
        $error("%s: expected %0d, got %0d", name, e, g);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      reports++;
      if (report_q.size() == 0) begin
        $error("unexpected out beat %p", got);
        errors++;
        return;
      end
      e = report_q.pop_front();
      cmp("found", e.found, got.found);
      cmp("rank_a", e.rank_a, got.rank_a);
      cmp("rank_b", e.rank_b, got.rank_b);
      cmp("sm_index", e.sm_index, got.sm_index);
      cmp("hosts_a", e.hosts_a, got.hosts_a);
      cmp("hosts_b", e.hosts_b, got.hosts_b);
      cmp("hosts_c", e.hosts_c, got.hosts_c);
      cmp("leftover_blocks_c", e.leftover_blocks_c, got.leftover_blocks_c);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  negotiator_sb sb;
  int items_sent;

  sm_corun_resource_negotiator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int stall_left;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  task automatic send(logic [OP_W-1:0] op, int sm, int tb, logic [KEY_W-1:0] key);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, sm_count: sm[SMF_W-1:0], blocks_per_sm: tb[TB_W-1:0],
                 time_key: key};
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic write_all(int ra, int sa, int rb, int sbv, int rc, int sc);
    write_reg(CFG_REGS_A, ra);
    write_reg(CFG_SMEM_A, sa);
    write_reg(CFG_REGS_B, rb);
    write_reg(CFG_SMEM_B, sbv);
    write_reg(CFG_REGS_C, rc);
    write_reg(CFG_SMEM_C, sc);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_regs();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return SM_REG_CAPACITY;
    return $urandom_range(1, 4096);
  endfunction

  function automatic int rand_smem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r == 2) return SM_SMEM_CAPACITY;
    return $urandom_range(1, 3072);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 15);
  endfunction

  function automatic int rand_sm();
    if ($urandom_range(0, 9) == 0) return 31;
    return $urandom_range(0, 30);
  endfunction

  task automatic random_phase(int max_len);
    int na, nb;
    write_all(rand_regs(), rand_smem(), rand_regs(), rand_smem(),
              ($urandom_range(0, 15) == 0) ? 0 : rand_regs() | 1, rand_smem());
    na = $urandom_range(0, max_len);
    nb = $urandom_range(0, max_len);
    while (na + nb > 0) begin
      if ($urandom_range(0, 19) == 0)
        send(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 63), $urandom);
      if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
        send(OP_LOAD_A, rand_sm(), $urandom_range(0, 63), rand_key());
        na--;
      end else begin
        send(OP_LOAD_B, rand_sm(), $urandom_range(0, 63), rand_key());
        nb--;
      end
    end
    send(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 63), $urandom);
    settle();
  endtask

  initial begin
    #(60_000_000);
    $display("sm_corun_resource_negotiator_core_tb: errors");
    $finish;
  end

  initial begin
    sb = new();
    sb.rpb_c = 1;
    items_sent = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_RUN, 0, 0, 0);
    settle();
    write_all(2048, 1024, 1024, 2048, 256, 512);
    send(OP_LOAD_A, 31, 63, 32'hFFFF_FFFF);
    send(OP_LOAD_A, 3, 8, 5);
    send(OP_LOAD_A, 2, 4, 5);
    send(OP_LOAD_B, 31, 10, 1);
    send(OP_LOAD_B, 0, 0, 0);
    send(OP_LOAD_B, 30, 32, 5);
    send(OP_UNUSED, 31, 63, 32'hFFFF_FFFF);
    send(OP_RUN, 31, 63, 32'hFFFF_FFFF);
    settle();
    write_all(SM_REG_CAPACITY, SM_SMEM_CAPACITY, 0, 65535, 0, 0);
    send(OP_LOAD_A, 30, 1, 0);
    send(OP_LOAD_B, 30, 63, 0);
    send(OP_LOAD_B, 1, 0, 0);
    send(OP_RUN, 0, 0, 0);
    settle();
    write_all(4096, 0, 4096, 0, SM_REG_CAPACITY, SM_SMEM_CAPACITY);
    send(OP_LOAD_A, 15, 16, 2);
    send(OP_LOAD_A, 20, 1, 9);
    send(OP_LOAD_B, 20, 16, 3);
    send(OP_LOAD_B, 10, 8, 4);
    send(OP_RUN, 0, 0, 0);
    settle();

    write_all(1, 1, 1, 1, 1, 1);
    for (int i = 0; i < MAX_PROFILES + 2; i++)
      send(OP_LOAD_A, rand_sm(), $urandom_range(0, 63), rand_key());
    for (int i = 0; i < MAX_PROFILES + 2; i++)
      send(OP_LOAD_B, rand_sm(), $urandom_range(0, 63), rand_key());
    send(OP_RUN, 0, 0, 0);
    settle();

    while (items_sent < 300) random_phase(($urandom_range(0, 7) == 0) ? 14 : 5);
    settle();

    $display("Covered %0d input beats over %0d runs; %0d runs found a pairing, %0d reports.",
             items_sent, sb.runs, sb.found_runs, sb.reports);
    if (sb.errors == 0 && sb.report_q.size() == 0) begin
      $display("sm_corun_resource_negotiator_core_tb: clean");
    end else begin
      $display("sm_corun_resource_negotiator_core_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
